@@ rtl/bthd_pkg.sv @@
package bthd_pkg;

    localparam int TIME_BITS = 32;
    localparam int NOW_BITS  = 32;
    localparam int CFG_BITS  = 16;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 4;

    typedef logic [TIME_BITS-1:0] stamp_t;
    typedef logic [CFG_BITS-1:0]  cfg_t;

    typedef enum logic [1:0] {
        REG_HOLD_MIN   = 2'd0,
        REG_DOWN_DELAY = 2'd1,
        REG_UP_DELAY   = 2'd2,
        REG_TAP_DELAY  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic hold_fired;
        logic down_fired;
        logic up_fired;
        logic tap_fired;
    } events_t;

    function automatic stamp_t to_stamp(input logic [NOW_BITS-1:0] now);
        return TIME_BITS'(64'(now));
    endfunction

    function automatic stamp_t elapsed(input stamp_t now, input stamp_t then);
        return now - then;
    endfunction

    function automatic stamp_t widen_cfg(input cfg_t value);
        return TIME_BITS'(64'(value));
    endfunction

endpackage

@@ rtl/button_tap_hold_event_detector_top.sv @@
// Tap/hold detector for an active-low button. Each input transaction carries one pin sample
// (0 = pressed) and a millisecond timestamp; each produces exactly one output transaction
// with four event flags: hold, delayed down, delayed up and delayed tap. A sample is
// captured in an input register, evaluated against the tracking state in one pass and
// written to the output register, so one sample is taken per clock cycle; the only stall
// is a full output register that is not being drained.
// Timestamps wrap modulo 2^TIME_BITS. The four 16-bit delay registers sit on the APB
// port at byte addresses 0, 4, 8 and 12 and should be written only while the block is idle.
module button_tap_hold_event_detector_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          pin_level,
    input  logic [bthd_pkg::NOW_BITS-1:0] now_ms,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hold_fired,
    output logic                          down_fired,
    output logic                          up_fired,
    output logic                          tap_fired,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bthd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bthd_pkg::DATA_BITS-1:0] pwdata,
    output logic [bthd_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import bthd_pkg::*;

    cfg_t     hold_min_reg;
    cfg_t     down_delay_reg;
    cfg_t     up_delay_reg;
    cfg_t     tap_delay_reg;
    reg_idx_t cfg_idx;
    logic     cfg_write;

    logic     in_valid_reg;
    logic     level_reg;
    stamp_t   now_reg;
    logic     out_valid_reg;
    events_t  events_reg;
    events_t  events_next;
    logic     advance;

    logic     pressed_reg;
    stamp_t   press_start_reg;
    logic     hold_seen_reg;
    logic     down_pending_reg;
    stamp_t   down_time_reg;
    logic     up_pending_reg;
    stamp_t   up_time_reg;
    logic     tap_pending_reg;
    stamp_t   tap_time_reg;

    logic     pressed_next;
    stamp_t   press_start_next;
    logic     hold_seen_next;
    logic     down_pending_next;
    stamp_t   down_time_next;
    logic     up_pending_next;
    stamp_t   up_time_next;
    logic     tap_pending_next;
    stamp_t   tap_time_next;

    assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            REG_HOLD_MIN:   prdata = DATA_BITS'(hold_min_reg);
            REG_DOWN_DELAY: prdata = DATA_BITS'(down_delay_reg);
            REG_UP_DELAY:   prdata = DATA_BITS'(up_delay_reg);
            REG_TAP_DELAY:  prdata = DATA_BITS'(tap_delay_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_min_reg   <= '0;
            down_delay_reg <= '0;
            up_delay_reg   <= '0;
            tap_delay_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_HOLD_MIN:   hold_min_reg   <= pwdata[CFG_BITS-1:0];
                REG_DOWN_DELAY: down_delay_reg <= pwdata[CFG_BITS-1:0];
                REG_UP_DELAY:   up_delay_reg   <= pwdata[CFG_BITS-1:0];
                REG_TAP_DELAY:  tap_delay_reg  <= pwdata[CFG_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        pressed_next      = pressed_reg;
        press_start_next  = press_start_reg;
        hold_seen_next    = hold_seen_reg;
        down_pending_next = down_pending_reg;
        down_time_next    = down_time_reg;
        up_pending_next   = up_pending_reg;
        up_time_next      = up_time_reg;
        tap_pending_next  = tap_pending_reg;
        tap_time_next     = tap_time_reg;
        events_next       = '0;

        if (!level_reg)
        begin
            if (!pressed_reg)
            begin
                pressed_next      = 1'b1;
                press_start_next  = now_reg;
                down_pending_next = 1'b1;
                down_time_next    = now_reg;
            end
            else if (!hold_seen_reg && (hold_min_reg != '0) &&
                     (elapsed(now_reg, press_start_reg) >= widen_cfg(hold_min_reg)))
            begin
                events_next.hold_fired = 1'b1;
                hold_seen_next         = 1'b1;
            end
        end
        else if (pressed_reg)
        begin
            up_pending_next = 1'b1;
            up_time_next    = now_reg;
            if (!hold_seen_reg)
            begin
                tap_pending_next = 1'b1;
                tap_time_next    = now_reg;
            end
            pressed_next   = 1'b0;
            hold_seen_next = 1'b0;
        end

        if (down_pending_next &&
            (elapsed(now_reg, down_time_next) > widen_cfg(down_delay_reg)))
        begin
            events_next.down_fired = 1'b1;
            down_pending_next      = 1'b0;
        end
        if (up_pending_next &&
            (elapsed(now_reg, up_time_next) > widen_cfg(up_delay_reg)))
        begin
            events_next.up_fired = 1'b1;
            up_pending_next      = 1'b0;
        end
        if (tap_pending_next &&
            (elapsed(now_reg, tap_time_next) > widen_cfg(tap_delay_reg)))
        begin
            events_next.tap_fired = 1'b1;
            tap_pending_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pressed_reg      <= 1'b0;
            press_start_reg  <= '0;
            hold_seen_reg    <= 1'b0;
            down_pending_reg <= 1'b0;
            down_time_reg    <= '0;
            up_pending_reg   <= 1'b0;
            up_time_reg      <= '0;
            tap_pending_reg  <= 1'b0;
            tap_time_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                pressed_reg      <= pressed_next;
                press_start_reg  <= press_start_next;
                hold_seen_reg    <= hold_seen_next;
                down_pending_reg <= down_pending_next;
                down_time_reg    <= down_time_next;
                up_pending_reg   <= up_pending_next;
                up_time_reg      <= up_time_next;
                tap_pending_reg  <= tap_pending_next;
                tap_time_reg     <= tap_time_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            level_reg <= pin_level;
            now_reg   <= to_stamp(now_ms);
        end
        if (advance)
        begin
            events_reg <= events_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hold_fired = events_reg.hold_fired;
    assign down_fired = events_reg.down_fired;
    assign up_fired   = events_reg.up_fired;
    assign tap_fired  = events_reg.tap_fired;

    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a blocked output");

    a_hold_only_while_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        hold_seen_reg |-> pressed_reg)
        else $error("hold flag set while released");

    a_release_clears_press: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && level_reg) |=> (!pressed_reg && !hold_seen_reg))
        else $error("release sample left press state set");

endmodule

@@ bench/button_tap_hold_event_detector_top_tb.sv @@
`timescale 1ns / 100ps

module button_tap_hold_event_detector_top_tb;

    import bthd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 250;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 pin_level;
    logic [NOW_BITS-1:0]  now_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hold_fired;
    logic                 down_fired;
    logic                 up_fired;
    logic                 tap_fired;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    cfg_t        reg_shadow [4];
    bit          is_down;
    bit          hold_latched;
    bit          down_armed;
    bit          up_armed;
    bit          tap_armed;
    stamp_t      press_stamp;
    stamp_t      down_stamp;
    stamp_t      up_stamp;
    stamp_t      tap_stamp;

    events_t     expected_events [$];
    stamp_t      wall_ms;
    bit          quiet_run;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned settings_used;
    int unsigned cycle_count;

    button_tap_hold_event_detector_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pin_level  (pin_level),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hold_fired (hold_fired),
        .down_fired (down_fired),
        .up_fired   (up_fired),
        .tap_fired  (tap_fired),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_events.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit is_due(input bit armed, input stamp_t at, input cfg_t delay,
                                  input stamp_t now);
        stamp_t gap;
        gap = now - at;
        return armed && (gap > stamp_t'(delay));
    endfunction

    function automatic events_t predict_events(input logic level, input stamp_t now);
        events_t ev;
        stamp_t  held;
        ev   = '0;
        held = now - press_stamp;
        if (!level)
        begin
            if (!is_down)
            begin
                is_down     = 1'b1;
                press_stamp = now;
                down_armed  = 1'b1;
                down_stamp  = now;
            end
            else if (!hold_latched && reg_shadow[REG_HOLD_MIN] != '0 &&
                     held >= stamp_t'(reg_shadow[REG_HOLD_MIN]))
            begin
                ev.hold_fired = 1'b1;
                hold_latched  = 1'b1;
            end
        end
        else if (is_down)
        begin
            up_armed = 1'b1;
            up_stamp = now;
            if (!hold_latched)
            begin
                tap_armed = 1'b1;
                tap_stamp = now;
            end
            is_down      = 1'b0;
            hold_latched = 1'b0;
        end
        ev.down_fired = is_due(down_armed, down_stamp, reg_shadow[REG_DOWN_DELAY], now);
        ev.up_fired   = is_due(up_armed, up_stamp, reg_shadow[REG_UP_DELAY], now);
        ev.tap_fired  = is_due(tap_armed, tap_stamp, reg_shadow[REG_TAP_DELAY], now);
        if (ev.down_fired)
            down_armed = 1'b0;
        if (ev.up_fired)
            up_armed = 1'b0;
        if (ev.tap_fired)
            tap_armed = 1'b0;
        return ev;
    endfunction

    // check every output transaction against the oldest prediction
    always @(posedge clk)
    begin
        events_t got;
        events_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {hold_fired, down_fired, up_fired, tap_fired};
            results_seen++;
            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result %0d: hold/down/up/tap %b", results_seen, got);
            end
            else
            begin
                want = expected_events.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result %0d: hold/down/up/tap expected %b, got %b",
                                 results_seen, want, got);
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = quiet_run || ($urandom_range(0, 99) >= 30);
        end
    end

    task automatic send_sample(input logic level, input stamp_t stamp);
        if (!quiet_run)
            while ($urandom_range(0, 99) < 30)
                @(negedge clk);
        in_valid  = 1'b1;
        pin_level = level;
        now_ms    = stamp;
        do
            @(posedge clk);
        while (!in_ready);
        expected_events.push_back(predict_events(level, stamp));
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain_events();
        while (expected_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input cfg_t value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom()), value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        reg_shadow[idx] = value;
    endtask

    task automatic write_all(input cfg_t hold_min, input cfg_t down_delay,
                             input cfg_t up_delay, input cfg_t tap_delay);
        drain_events();
        write_reg(REG_HOLD_MIN, hold_min);
        write_reg(REG_DOWN_DELAY, down_delay);
        write_reg(REG_UP_DELAY, up_delay);
        write_reg(REG_TAP_DELAY, tap_delay);
        settings_used++;
    endtask

    function automatic stamp_t advance_clock(input int unsigned step_max);
        if ($urandom_range(0, 99) < 2)
            wall_ms = $urandom();
        else
            wall_ms = wall_ms + $urandom_range(0, step_max);
        return wall_ms;
    endfunction

    function automatic cfg_t pick_cfg();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return cfg_t'($urandom_range(1, 40));
            default: return cfg_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // reset settings: hold off, every delay zero, press at time zero
    task automatic test_reset_settings();
        send_sample(1'b1, 32'd0);
        send_sample(1'b0, 32'd0);
        send_sample(1'b0, 32'd1);
        send_sample(1'b0, 32'd200000);
        send_sample(1'b1, 32'd200000);
        send_sample(1'b1, 32'd200001);
    endtask

    // hold, delayed down and up across the timestamp wrap
    task automatic test_hold_and_delays();
        write_all(16'd5, 16'd3, 16'd2, 16'd4);
        send_sample(1'b0, 32'hFFFF_FFFE);
        send_sample(1'b0, 32'h0000_0001);
        send_sample(1'b0, 32'h0000_0002);
        send_sample(1'b0, 32'h0000_0003);
        send_sample(1'b0, 32'h0000_0009);
        send_sample(1'b1, 32'h0000_000A);
        send_sample(1'b1, 32'h0000_000D);
    endtask

    // re-arm pending events before they fire; each fires once
    task automatic test_rearm();
        send_sample(1'b0, 32'd20);
        send_sample(1'b1, 32'd21);
        send_sample(1'b0, 32'd22);
        send_sample(1'b1, 32'd23);
        send_sample(1'b1, 32'd30);
        send_sample(1'b1, 32'd40);
    endtask

    task automatic test_limits();
        write_all('1, '1, '1, '1);
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0000_FFFE);
        send_sample(1'b0, 32'h0000_FFFF);
        send_sample(1'b1, 32'h0001_0000);
        send_sample(1'b1, 32'h0002_0000);
        send_sample(1'b1, 32'h0002_0001);
    endtask

    task automatic run_phase(input int unsigned count, input int unsigned step_max);
        int unsigned target;
        int unsigned run;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                run = $urandom_range(1, 8);
                repeat (run) send_sample(1'b0, advance_clock(step_max));
                run = $urandom_range(1, 6);
                repeat (run) send_sample(1'b1, advance_clock(step_max));
            end
            else
                send_sample(1'($urandom_range(0, 1)), advance_clock(step_max));
        end
    endtask

    task automatic test_random_phases();
        cfg_t        picks [4];
        int unsigned largest;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            for (int i = 0; i < 4; i++)
                picks[i] = (phase == 0) ? cfg_t'(0) : (phase == 1) ? cfg_t'('1) : pick_cfg();
            write_all(picks[0], picks[1], picks[2], picks[3]);
            largest = 0;
            for (int i = 0; i < 4; i++)
                if (32'(picks[i]) > largest)
                    largest = 32'(picks[i]);
            wall_ms   = $urandom();
            quiet_run = (phase == 2);
            run_phase(PHASE_ITEMS, largest / 3 + 2);
        end
        quiet_run = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pin_level = 1'b1;
        now_ms    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        quiet_run = 1'b0;
        for (int i = 0; i < 4; i++)
            reg_shadow[i] = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_settings();
        test_hold_and_delays();
        test_rearm();
        test_limits();
        test_random_phases();

        drain_events();
        repeat (8) @(negedge clk);
        $display("sent %0d samples, checked %0d results across %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
